// ===== hdl/dcso_pkg.sv =====
// Package for the DC motor state observer: micro-program types, codes and gain constants.
// It has no dependencies and is used by dc_motor_state_observer.
`default_nettype none

package dcso_pkg;

  localparam int unsigned TERM_CNT = 26;
  localparam logic [4:0] LAST_TERM = 5'd25;

  typedef enum logic [4:0] {
    SRC_ONE, SRC_COEF, SRC_U, SRC_W, SRC_DW, SRC_UP, SRC_X0, SRC_X1, SRC_X2,
    SRC_CUR, SRC_T1, SRC_T2, SRC_D, SRC_K, SRC_LAM, SRC_KM, SRC_KW
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_UP, DST_NX0, DST_NX1, DST_NX2, DST_MT, DST_T1, DST_T2, DST_D, DST_LOAD
  } dst_t;

  typedef enum logic [1:0] {
    ACT_R32, ACT_R24, ACT_R0, ACT_R32NEG
  } act_t;

  localparam logic [1:0] CFG_LAM = 2'd0;
  localparam logic [1:0] CFG_KM  = 2'd1;
  localparam logic [1:0] CFG_R   = 2'd2;
  localparam logic [1:0] CFG_KW  = 2'd3;

  typedef struct packed {
    src_t               src_a;
    src_t               src_b;
    logic signed [63:0] coef;
    logic               sub;
    logic               last;
    act_t               act;
    dst_t               dst;
  } term_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } opnd_t;

  localparam logic signed [63:0] VSCALE = 64'sd4073060652;

  localparam logic signed [63:0] A00 = 64'sd2925216326;
  localparam logic signed [63:0] A01 = 64'sd202379;
  localparam logic signed [63:0] A02 = 64'sd466905895;
  localparam logic signed [63:0] A10 = -64'sd92006359918;
  localparam logic signed [63:0] A11 = 64'sd4028529000;
  localparam logic signed [63:0] A12 = -64'sd1877795350040;
  localparam logic signed [63:0] A20 = -64'sd213497670;
  localparam logic signed [63:0] A21 = -64'sd14223;
  localparam logic signed [63:0] A22 = -64'sd34056514;
  localparam logic signed [63:0] BU0 = 64'sd4928474972;
  localparam logic signed [63:0] BU1 = 64'sd424470329373;
  localparam logic signed [63:0] BU2 = 64'sd985437296;
  localparam logic signed [63:0] BW0 = 64'sd71425306;
  localparam logic signed [63:0] BW1 = -64'sd2023788590;
  localparam logic signed [63:0] BW2 = -64'sd5077510;
  localparam logic signed [63:0] BD0 = -64'sd202379;
  localparam logic signed [63:0] BD1 = 64'sd90172838;
  localparam logic signed [63:0] BD2 = 64'sd14223;

  function automatic term_t mk(src_t a, src_t b, logic signed [63:0] c, logic sub,
                               logic last, act_t act, dst_t dst);
    term_t t;
    t.src_a = a;
    t.src_b = b;
    t.coef  = c;
    t.sub   = sub;
    t.last  = last;
    t.act   = act;
    t.dst   = dst;
    return t;
  endfunction

  function automatic term_t term_f(logic [4:0] idx);
    term_t t;
    unique case (idx)
      5'd0:  t = mk(SRC_COEF, SRC_U,   VSCALE, 1'b0, 1'b1, ACT_R32, DST_UP);
      5'd1:  t = mk(SRC_COEF, SRC_UP,  BU0, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd2:  t = mk(SRC_COEF, SRC_X0,  A00, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd3:  t = mk(SRC_COEF, SRC_X1,  A01, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd4:  t = mk(SRC_COEF, SRC_X2,  A02, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd5:  t = mk(SRC_COEF, SRC_W,   BW0, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd6:  t = mk(SRC_COEF, SRC_DW,  BD0, 1'b0, 1'b1, ACT_R32, DST_NX0);
      5'd7:  t = mk(SRC_COEF, SRC_UP,  BU1, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd8:  t = mk(SRC_COEF, SRC_X0,  A10, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd9:  t = mk(SRC_COEF, SRC_X1,  A11, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd10: t = mk(SRC_COEF, SRC_X2,  A12, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd11: t = mk(SRC_COEF, SRC_W,   BW1, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd12: t = mk(SRC_COEF, SRC_DW,  BD1, 1'b0, 1'b1, ACT_R32, DST_NX1);
      5'd13: t = mk(SRC_COEF, SRC_UP,  BU2, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd14: t = mk(SRC_COEF, SRC_X0,  A20, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd15: t = mk(SRC_COEF, SRC_X1,  A21, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd16: t = mk(SRC_COEF, SRC_X2,  A22, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd17: t = mk(SRC_COEF, SRC_W,   BW2, 1'b0, 1'b0, ACT_R32, DST_NONE);
      5'd18: t = mk(SRC_COEF, SRC_DW,  BD2, 1'b0, 1'b1, ACT_R32, DST_NX2);
      5'd19: t = mk(SRC_KM,   SRC_CUR, 64'sd0, 1'b0, 1'b1, ACT_R24, DST_MT);
      5'd20: t = mk(SRC_LAM,  SRC_W,   64'sd0, 1'b0, 1'b1, ACT_R24, DST_T1);
      5'd21: t = mk(SRC_KW,   SRC_W,   64'sd0, 1'b0, 1'b1, ACT_R24, DST_T2);
      5'd22: t = mk(SRC_ONE,  SRC_UP,  64'sd0, 1'b0, 1'b0, ACT_R0, DST_NONE);
      5'd23: t = mk(SRC_ONE,  SRC_T2,  64'sd0, 1'b1, 1'b1, ACT_R0, DST_D);
      5'd24: t = mk(SRC_K,    SRC_D,   64'sd0, 1'b0, 1'b1, ACT_R32NEG, DST_NONE);
      5'd25: t = mk(SRC_ONE,  SRC_T1,  64'sd0, 1'b0, 1'b1, ACT_R0, DST_LOAD);
      default: t = mk(SRC_ONE, SRC_ONE, 64'sd0, 1'b0, 1'b1, ACT_R0, DST_NONE);
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dc_motor_state_observer.sv =====
// Top level of the DC motor state observer: sequencer, shared 32x32 multiply-accumulate unit
// and serial divider for the Km/R ratio. Depends on dcso_pkg.
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | voltage_cmd, speed_meas, accel_meas
// out     | output    | out_valid / out_ready| est_speed, est_accel, est_current, torques
// cfg     | input     | cfg_we               | cfg_index, cfg_wdata
// Each request runs 26 product terms of 4 partial products each through the single 32x32
// multiplier, with a drain and a write-back state for each of the 10 result steps, then an
// output state before the block returns to idle.
// The Km/R divider runs in parallel with the product terms and never lengthens the sequence.
// Synchronous active-low reset clears the observer state and loads the default registers.
// A new request is taken only while idle; a result waiting on a stalled output holds the block.

module dc_motor_state_observer #(
  parameter int FRAC_BITS  = 24,
  parameter int DATA_WIDTH = 48
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire signed [DATA_WIDTH-1:0] in_voltage_cmd,
  input  wire signed [DATA_WIDTH-1:0] in_speed_meas,
  input  wire signed [DATA_WIDTH-1:0] in_accel_meas,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_est_speed,
  output logic signed [DATA_WIDTH-1:0] out_est_accel,
  output logic signed [DATA_WIDTH-1:0] out_est_current,
  output logic signed [DATA_WIDTH-1:0] out_motor_torque,
  output logic signed [DATA_WIDTH-1:0] out_load_torque,
  input  wire                         cfg_we,
  input  wire [1:0]                   cfg_index,
  input  wire [31:0]                  cfg_wdata
);

  localparam logic [63:0] THR = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic signed [127:0] MAXV = (128'sd1 <<< (DATA_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] MINV = -(128'sd1 <<< (DATA_WIDTH - 1));

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_END   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] lam_r, km_r, res_r, kw_r;
  logic signed [DATA_WIDTH-1:0] x_r [3];
  logic signed [DATA_WIDTH-1:0] nx_r [3];
  logic signed [DATA_WIDTH-1:0] u_r, w_r, dw_r, up_r, mt_r, t1_r, t2_r, d_r, load_r;
  logic [4:0]   idx_r;
  logic [1:0]   pp_r;
  logic signed [127:0] acc_r;
  logic [63:0]  prod_r;
  logic [1:0]   prod_sh_r;
  logic         prod_neg_r, prod_v_r;

  logic [63:0]  div_num_r, div_q_r;
  logic [32:0]  div_rem_r;
  logic [6:0]   div_cnt_r;
  logic         div_busy_r;

  dcso_pkg::term_t term;
  dcso_pkg::opnd_t op_a, op_b;
  logic signed [DATA_WIDTH-1:0] cur;
  logic         issue;
  logic [31:0]  ah, bh;
  logic signed [127:0] addend, rnd, satv_full;
  logic signed [DATA_WIDTH-1:0] satv;
  logic [32:0]  rem_sh;
  logic [31:0]  res_eff;

  function automatic logic signed [63:0] ext64(logic signed [DATA_WIDTH-1:0] v);
    return 64'(v);
  endfunction

  function automatic dcso_pkg::opnd_t to_op(logic signed [63:0] v, logic uns);
    dcso_pkg::opnd_t o;
    o.neg = !uns && v[63];
    o.mag = o.neg ? 64'(-v) : 64'(v);
    return o;
  endfunction

  function automatic dcso_pkg::opnd_t src_op(dcso_pkg::src_t s);
    dcso_pkg::opnd_t o;
    unique case (s)
      dcso_pkg::SRC_ONE:  o = to_op(64'sd1, 1'b1);
      dcso_pkg::SRC_COEF: o = to_op(term.coef, 1'b0);
      dcso_pkg::SRC_U:    o = to_op(ext64(u_r), 1'b0);
      dcso_pkg::SRC_W:    o = to_op(ext64(w_r), 1'b0);
      dcso_pkg::SRC_DW:   o = to_op(ext64(dw_r), 1'b0);
      dcso_pkg::SRC_UP:   o = to_op(ext64(up_r), 1'b0);
      dcso_pkg::SRC_X0:   o = to_op(ext64(x_r[0]), 1'b0);
      dcso_pkg::SRC_X1:   o = to_op(ext64(x_r[1]), 1'b0);
      dcso_pkg::SRC_X2:   o = to_op(ext64(x_r[2]), 1'b0);
      dcso_pkg::SRC_CUR:  o = to_op(ext64(cur), 1'b0);
      dcso_pkg::SRC_T1:   o = to_op(ext64(t1_r), 1'b0);
      dcso_pkg::SRC_T2:   o = to_op(ext64(t2_r), 1'b0);
      dcso_pkg::SRC_D:    o = to_op(ext64(d_r), 1'b0);
      dcso_pkg::SRC_K:    o = to_op(div_q_r, 1'b1);
      dcso_pkg::SRC_LAM:  o = to_op({32'd0, lam_r}, 1'b1);
      dcso_pkg::SRC_KM:   o = to_op({32'd0, km_r}, 1'b1);
      dcso_pkg::SRC_KW:   o = to_op({32'd0, kw_r}, 1'b1);
      default:            o = to_op(64'sd0, 1'b1);
    endcase
    return o;
  endfunction

  assign term = dcso_pkg::term_f(idx_r);

  always_comb begin
    op_a = src_op(term.src_a);
    op_b = src_op(term.src_b);
  end

  assign ah = pp_r[1] ? op_a.mag[63:32] : op_a.mag[31:0];
  assign bh = pp_r[0] ? op_b.mag[63:32] : op_b.mag[31:0];
  assign issue = (state_r == S_MUL) &&
                 !((term.src_a == dcso_pkg::SRC_K) && (div_busy_r || div_cnt_r != 7'd0));

  always_comb begin
    logic [63:0] nx2_mag;
    nx2_mag = nx_r[2][DATA_WIDTH-1] ? 64'(-ext64(nx_r[2])) : 64'(ext64(nx_r[2]));
    cur = (nx2_mag < THR) ? '0 : nx_r[2];
  end

  assign addend = signed'({64'd0, prod_r} << {prod_sh_r, 5'd0});

  always_comb begin
    unique case (term.act)
      dcso_pkg::ACT_R32, dcso_pkg::ACT_R32NEG: rnd = (acc_r + (128'sd1 <<< 31)) >>> 32;
      dcso_pkg::ACT_R24: rnd = (acc_r + (128'sd1 <<< 23)) >>> 24;
      dcso_pkg::ACT_R0:  rnd = acc_r;
      default:           rnd = acc_r;
    endcase
    if (rnd > MAXV) begin
      satv_full = MAXV;
    end else if (rnd < MINV) begin
      satv_full = MINV;
    end else begin
      satv_full = rnd;
    end
    satv = satv_full[DATA_WIDTH-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   if (issue && pp_r == 2'd3 && term.last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_END;
      S_END:   state_nxt = (idx_r == dcso_pkg::LAST_TERM) ? S_OUT : S_MUL;
      S_OUT:   if (!out_valid || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign res_eff = (res_r == 32'd0) ? 32'd1 : res_r;
  assign rem_sh = {div_rem_r[31:0], div_num_r[63]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      lam_r      <= 32'd33554;
      km_r       <= 32'd32609876;
      res_r      <= 32'd99057716;
      kw_r       <= 32'd32609876;
      x_r[0]     <= '0;
      x_r[1]     <= '0;
      x_r[2]     <= '0;
      out_valid  <= 1'b0;
      prod_v_r   <= 1'b0;
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      idx_r      <= '0;
      pp_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          dcso_pkg::CFG_LAM: lam_r <= cfg_wdata;
          dcso_pkg::CFG_KM:  km_r  <= cfg_wdata;
          dcso_pkg::CFG_R:   res_r <= cfg_wdata;
          dcso_pkg::CFG_KW:  kw_r  <= cfg_wdata;
          default:           lam_r <= lam_r;
        endcase
      end
      prod_v_r <= issue;
      if (state_r == S_IDLE && in_valid) begin
        idx_r      <= '0;
        pp_r       <= '0;
        div_busy_r <= 1'b1;
        div_cnt_r  <= 7'd64;
      end
      if (div_busy_r) begin
        div_cnt_r <= div_cnt_r - 7'd1;
        if (div_cnt_r == 7'd1) begin
          div_busy_r <= 1'b0;
        end
      end
      if (issue) begin
        pp_r <= pp_r + 2'd1;
        if (pp_r == 2'd3 && !term.last) begin
          idx_r <= idx_r + 5'd1;
        end
      end
      if (state_r == S_END && idx_r != dcso_pkg::LAST_TERM) begin
        idx_r <= idx_r + 5'd1;
      end
      if (state_r == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        x_r[0]    <= nx_r[0];
        x_r[1]    <= nx_r[1];
        x_r[2]    <= nx_r[2];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      u_r       <= in_voltage_cmd;
      w_r       <= in_speed_meas;
      dw_r      <= in_accel_meas;
      acc_r     <= '0;
      div_num_r <= {km_r, 32'd0};
      div_rem_r <= '0;
      div_q_r   <= '0;
    end else begin
      if (div_busy_r) begin
        div_num_r <= {div_num_r[62:0], 1'b0};
        if (rem_sh >= {1'b0, res_eff}) begin
          div_rem_r <= rem_sh - {1'b0, res_eff};
          div_q_r   <= {div_q_r[62:0], 1'b1};
        end else begin
          div_rem_r <= rem_sh;
          div_q_r   <= {div_q_r[62:0], 1'b0};
        end
      end
      if (prod_v_r) begin
        acc_r <= prod_neg_r ? acc_r - addend : acc_r + addend;
      end else if (state_r == S_END) begin
        acc_r <= (term.act == dcso_pkg::ACT_R32NEG) ? -rnd : '0;
      end
    end
    if (issue) begin
      prod_r     <= 64'(ah) * 64'(bh);
      prod_sh_r  <= 2'({1'b0, pp_r[1]} + {1'b0, pp_r[0]});
      prod_neg_r <= op_a.neg ^ op_b.neg ^ term.sub;
    end
    if (state_r == S_END) begin
      unique case (term.dst)
        dcso_pkg::DST_UP:   up_r   <= satv;
        dcso_pkg::DST_NX0:  nx_r[0] <= satv;
        dcso_pkg::DST_NX1:  nx_r[1] <= satv;
        dcso_pkg::DST_NX2:  nx_r[2] <= satv;
        dcso_pkg::DST_MT:   mt_r   <= satv;
        dcso_pkg::DST_T1:   t1_r   <= satv;
        dcso_pkg::DST_T2:   t2_r   <= satv;
        dcso_pkg::DST_D:    d_r    <= satv;
        dcso_pkg::DST_LOAD: load_r <= satv;
        dcso_pkg::DST_NONE: up_r   <= up_r;
        default:            up_r   <= up_r;
      endcase
    end
    if (state_r == S_OUT && (!out_valid || out_ready)) begin
      out_est_speed    <= nx_r[0];
      out_est_accel    <= nx_r[1];
      out_est_current  <= cur;
      out_motor_torque <= mt_r;
      out_load_torque  <= load_r;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/dc_motor_state_observer_chk.sv =====
// Result checker for the DC motor state observer: watches all three channels, predicts each
// result in 128-bit fixed point and compares field by field. Depends on dcso_pkg.
`timescale 1ns / 1ps

module dc_motor_state_observer_chk (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire signed [47:0] in_voltage_cmd,
  input  wire signed [47:0] in_speed_meas,
  input  wire signed [47:0] in_accel_meas,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire signed [47:0] out_est_speed,
  input  wire signed [47:0] out_est_accel,
  input  wire signed [47:0] out_est_current,
  input  wire signed [47:0] out_motor_torque,
  input  wire signed [47:0] out_load_torque,
  input  wire               cfg_we,
  input  wire [1:0]         cfg_index,
  input  wire [31:0]        cfg_wdata,
  output int                fail_count,
  output int                pending_count,
  output int                result_count
);

  typedef logic signed [47:0] d48_t;
  typedef logic signed [127:0] w_t;
  typedef struct packed {
    d48_t spd;
    d48_t acc;
    d48_t cur;
    d48_t mt;
    d48_t load;
  } est_t;

  localparam w_t MAXP = (w_t'(1) <<< 47) - 1;
  localparam w_t MINN = -(w_t'(1) <<< 47);
  localparam d48_t CUR_THR = 48'sd168;

  est_t est_q[$];
  d48_t obs_x[3];
  logic [31:0] lam, km, res, kw;

  function automatic w_t rnd(w_t a, int sh);
    return (a + (w_t'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic d48_t sat(w_t a);
    if (a > MAXP) return d48_t'(MAXP);
    if (a < MINN) return d48_t'(MINN);
    return d48_t'(a);
  endfunction

  function automatic est_t observe(d48_t u, d48_t w, d48_t dw);
    w_t gain_a[3][3];
    w_t gain_u[3], gain_w[3], gain_d[3];
    w_t acc, kr;
    d48_t up, t1, t2, dd, cur;
    d48_t nx[3];
    est_t e;
    logic [31:0] r;
    gain_a[0] = '{dcso_pkg::A00, dcso_pkg::A01, dcso_pkg::A02};
    gain_a[1] = '{dcso_pkg::A10, dcso_pkg::A11, dcso_pkg::A12};
    gain_a[2] = '{dcso_pkg::A20, dcso_pkg::A21, dcso_pkg::A22};
    gain_u = '{dcso_pkg::BU0, dcso_pkg::BU1, dcso_pkg::BU2};
    gain_w = '{dcso_pkg::BW0, dcso_pkg::BW1, dcso_pkg::BW2};
    gain_d = '{dcso_pkg::BD0, dcso_pkg::BD1, dcso_pkg::BD2};
    up = sat(rnd(w_t'(u) * w_t'(dcso_pkg::VSCALE), 32));
    for (int i = 0; i < 3; i++) begin
      acc = gain_u[i] * w_t'(up) + gain_w[i] * w_t'(w) + gain_d[i] * w_t'(dw);
      for (int j = 0; j < 3; j++) acc += gain_a[i][j] * w_t'(obs_x[j]);
      nx[i] = sat(rnd(acc, 32));
    end
    obs_x = nx;
    cur = ((nx[2] < 0 ? -w_t'(nx[2]) : w_t'(nx[2])) < w_t'(CUR_THR)) ? '0 : nx[2];
    e.spd = nx[0];
    e.acc = nx[1];
    e.cur = cur;
    e.mt = sat(rnd(w_t'(cur) * w_t'({1'b0, km}), 24));
    t1 = sat(rnd(w_t'(w) * w_t'({1'b0, lam}), 24));
    t2 = sat(rnd(w_t'(w) * w_t'({1'b0, kw}), 24));
    dd = sat(w_t'(up) - w_t'(t2));
    r = (res == 0) ? 32'd1 : res;
    kr = (w_t'({1'b0, km}) <<< 32) / w_t'({1'b0, r});
    e.load = sat(w_t'(t1) - rnd(w_t'(dd) * kr, 32));
    return e;
  endfunction

  task automatic cmp(string nm, d48_t exp_v, d48_t act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, nm, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    est_t e;
    if (!rst_n) begin
      obs_x = '{default: '0};
      lam = 32'd33554;
      km = 32'd32609876;
      res = 32'd99057716;
      kw = 32'd32609876;
      est_q.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dcso_pkg::CFG_LAM: lam = cfg_wdata;
          dcso_pkg::CFG_KM:  km = cfg_wdata;
          dcso_pkg::CFG_R:   res = cfg_wdata;
          dcso_pkg::CFG_KW:  kw = cfg_wdata;
          default:           lam = lam;
        endcase
      end
      if (in_valid && in_ready)
        est_q.push_back(observe(in_voltage_cmd, in_speed_meas, in_accel_meas));
      if (out_valid && out_ready) begin
        result_count++;
        if (est_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request outstanding", $time);
        end else begin
          e = est_q.pop_front();
          cmp("est_speed", e.spd, out_est_speed);
          cmp("est_accel", e.acc, out_est_accel);
          cmp("est_current", e.cur, out_est_current);
          cmp("motor_torque", e.mt, out_motor_torque);
          cmp("load_torque", e.load, out_load_torque);
        end
      end
    end
    pending_count = est_q.size();
  end
endmodule

// ===== tb/sv/dc_motor_state_observer_tb.sv =====
// Testbench top for the DC motor state observer: drives requests, register settings and
// output stalls; dc_motor_state_observer_chk checks results. Depends on dcso_pkg.
`timescale 1ns / 1ps

module dc_motor_state_observer_tb;

  localparam longint LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [47:0] in_voltage_cmd = '0, in_speed_meas = '0, in_accel_meas = '0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = dcso_pkg::CFG_LAM;
  logic [31:0] cfg_wdata = '0;
  logic in_ready, out_valid;
  logic signed [47:0] out_est_speed, out_est_accel, out_est_current;
  logic signed [47:0] out_motor_torque, out_load_torque;
  int fail_count, pending_count, result_count;
  int hold_off = 0;
  int sent = 0;
  longint cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dc_motor_state_observer i_dut (.*);
  dc_motor_state_observer_chk i_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("** dc_motor_state_observer: FAILED **");
      $finish;
    end
  end

  // The receiver mixes runs of full readiness, random stalls and requested long hold-offs.
  always @(negedge clk) begin
    int mode;
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else begin
      mode = int'((cycles / 700) % 3);
      if (mode == 0) out_ready <= 1'b1;
      else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 9) < 3);
    end
  end

  function automatic logic signed [47:0] rand48();
    logic signed [47:0] v;
    v = 48'({$urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: v = v >>> $urandom_range(24, 46);
      1: v = v >>> $urandom_range(8, 23);
      2: v = {48{v[47]}} ^ 48'sd1;
      default: v = v >>> 20;
    endcase
    return v;
  endfunction

  task automatic send(logic signed [47:0] u, logic signed [47:0] w, logic signed [47:0] dw);
    in_valid <= 1'b1;
    in_voltage_cmd <= u;
    in_speed_meas <= w;
    in_accel_meas <= dw;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (140) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst(int n);
    int left;
    left = n;
    while (left > 0) begin
      for (int b = $urandom_range(1, 8); b > 0 && left > 0; b--) begin
        send(rand48(), rand48(), rand48());
        left--;
      end
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 200)) @(negedge clk);
      end
    end
  endtask

  localparam logic signed [47:0] MAXV = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] MINV = 48'sh8000_0000_0000;

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send('0, '0, '0);
    send(MAXV, MAXV, MAXV);
    send(MINV, MINV, MINV);
    send(MAXV, MINV, '0);
    send(MINV, MAXV, MAXV);
    send(48'sd16777216, '0, '0);
    send('0, 48'sd16777216, '0);
    send('0, '0, 48'sd16777216);
    send(48'sd100, 48'sd3, -48'sd7);
    send(-48'sd1, -48'sd1, -48'sd1);
    send(48'sd201326592, 48'sd50331648, -48'sd16777216);
    send(48'sd201326592, 48'sd50331648, 48'sd0);
    drain();
    write_reg(dcso_pkg::CFG_R, 32'd0);
    write_reg(dcso_pkg::CFG_KM, 32'hffff_ffff);
    write_reg(dcso_pkg::CFG_LAM, 32'hffff_ffff);
    write_reg(dcso_pkg::CFG_KW, 32'd0);
    send(MAXV, MAXV, '0);
    send(48'sd16777216, -48'sd16777216, '0);
    send(MINV, 48'sd1000, '0);
    // Fill the block while the receiver holds off, then pause until all results are in.
    hold_off = 600;
    random_burst(6);
    drain();
    write_reg(dcso_pkg::CFG_LAM, 32'd0);
    write_reg(dcso_pkg::CFG_KM, 32'd0);
    write_reg(dcso_pkg::CFG_R, 32'hffff_ffff);
    write_reg(dcso_pkg::CFG_KW, 32'hffff_ffff);
    random_burst(150);
    drain();
    write_reg(dcso_pkg::CFG_LAM, 32'd33554);
    write_reg(dcso_pkg::CFG_KM, 32'd32609876);
    write_reg(dcso_pkg::CFG_R, 32'd99057716);
    write_reg(dcso_pkg::CFG_KW, 32'd32609876);
    random_burst(150);
    drain();
    for (int p = 0; p < 2; p++) begin
      write_reg(dcso_pkg::CFG_LAM, $urandom());
      write_reg(dcso_pkg::CFG_KM, $urandom());
      write_reg(dcso_pkg::CFG_R, $urandom_range(1, 32'hffff_ffff));
      write_reg(dcso_pkg::CFG_KW, $urandom());
      random_burst(150);
      drain();
    end
    $display("Sent %0d requests over six register settings, including extreme values;",
             sent);
    $display("%0d results checked with random input gaps and output stalls.", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** dc_motor_state_observer: PASSED **");
    end else begin
      $display("** dc_motor_state_observer: FAILED **");
    end
    $finish;
  end
endmodule
